// ===== src/sofbt_pkg.sv =====
// ============================================================================
// sofbt_pkg
// Shared types and constants of the size-ordered free-block table.
// ============================================================================
package sofbt_pkg;

  // Table geometry
  localparam int CAPACITY   = 64;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int PFX_LEVELS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Field widths of the request and response transactions
  localparam int REQ_W  = 2;
  localparam int KEY_W  = 32;
  localparam int ID_W   = 32;
  localparam int RANK_W = 6;
  localparam int OCC_W  = 7;
  localparam int STS_W  = 2;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2
  } req_code_t;

  // Response status codes
  typedef enum logic [STS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_RANK  = 2'd3
  } status_t;

  // One table entry
  typedef struct packed {
    logic [KEY_W-1:0] size;
    logic [ID_W-1:0]  id;
  } slot_t;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  ident;
  } cell_op_t;

endpackage

// ===== src/sofbt_req_if.sv =====
// ============================================================================
// sofbt_req_if
// Request channel: valid/ready handshake with the request payload.
// ============================================================================
interface sofbt_req_if
  import sofbt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [KEY_W-1:0]  block_size;
  logic [ID_W-1:0]   block_id;
  logic [RANK_W-1:0] rank;

  modport source (output valid, req_type, block_size, block_id, rank, input ready);
  modport sink   (input valid, req_type, block_size, block_id, rank, output ready);
endinterface

// ===== src/sofbt_rsp_if.sv =====
// ============================================================================
// sofbt_rsp_if
// Response channel: valid/ready handshake with the response payload.
// ============================================================================
interface sofbt_rsp_if
  import sofbt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [OCC_W-1:0] occupancy;
  logic [KEY_W-1:0] entry_size;
  logic [ID_W-1:0]  entry_id;

  modport source (output valid, status, occupancy, entry_size, entry_id, input ready);
  modport sink   (input valid, status, occupancy, entry_size, entry_id, output ready);
endinterface

// ===== src/sofbt_cell.sv =====
// ============================================================================
// sofbt_cell
// One slot of the ordered chain: holds an entry, compares it with the
// broadcast key and takes a neighbor's entry when the table shifts.
// ============================================================================
module sofbt_cell
  import sofbt_pkg::*;
(
  input  logic     clk,
  input  cell_op_t op,
  input  logic     here_valid,
  input  logic     left_lt,
  input  logic     shift,
  input  slot_t    left_slot,
  input  slot_t    right_slot,
  output slot_t    slot,
  output logic     lt,
  output logic     match
);

  slot_t slot_next;

  // Compare the held entry with the broadcast request
  assign lt    = here_valid && (slot.size < op.key);
  assign match = here_valid && (slot.size == op.key) && (slot.id == op.ident);

  // Keep, load the new entry, or take a neighbor's entry
  always_comb begin
    slot_next = slot;
    if (op.ins) begin
      if (!lt) begin
        if (left_lt) begin
          slot_next.size = op.key;
          slot_next.id   = op.ident;
        end else begin
          slot_next = left_slot;
        end
      end
    end else if (op.rem && shift) begin
      slot_next = right_slot;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

// ===== src/sofbt_prefix.sv =====
// ============================================================================
// sofbt_prefix
// Parallel prefix OR over the match flags of the chain: bit i is set when
// any cell at or below position i matches.
// ============================================================================
module sofbt_prefix
  import sofbt_pkg::*;
(
  input  logic [CAPACITY-1:0] flags,
  output logic [CAPACITY-1:0] prefix
);

  logic [CAPACITY-1:0] lvl [0:PFX_LEVELS];

  // Double the reach of every bit at each level
  always_comb begin
    lvl[0] = flags;
    for (int k = 0; k < PFX_LEVELS; k++) begin
      lvl[k+1] = lvl[k] | (lvl[k] << (1 << k));
    end
  end

  assign prefix = lvl[PFX_LEVELS];

endmodule

// ===== src/size_ordered_free_block_table.sv =====
// ============================================================================
// size_ordered_free_block_table
// Free-block table of a best-fit allocator, kept sorted by block size.
// ============================================================================
// Usage:
//   req : request transactions (insert, remove, read at rank) with block
//         size, block id and rank. Accepted when valid and ready are high.
//   rsp : one response per request: status, occupancy after the request,
//         and the entry read (zero for all but a successful read).
//   Each request is latched in a request register, then executed on the
//   chain of cells while the response register is loaded.
//   Response valid rises once the request has passed from the request
//   register into the response register. While the receiver takes every
//   response, the table sustains one request per cycle; the limit is the
//   single broadcast compare-and-shift pass through the chain.
//   Inserts place the entry ahead of equal sizes; removes take the first
//   entry matching size and id and shift the upper part down one slot.
//   Reset (synchronous, active high) empties the table at once.
//   When the receiver stalls, the response register holds and one further
//   request waits in the request register; then req.ready drops.
// ============================================================================
module size_ordered_free_block_table
  import sofbt_pkg::*;
(
  input logic         clk,
  input logic         rst,
  sofbt_req_if.sink   req,
  sofbt_rsp_if.source rsp
);

  // Request register
  logic              rq_valid;
  logic [REQ_W-1:0]  rq_type;
  logic [KEY_W-1:0]  rq_size;
  logic [ID_W-1:0]   rq_id;
  logic [RANK_W-1:0] rq_rank;

  // Table state
  logic [CNT_W-1:0]  held_count;
  logic [CNT_W-1:0]  held_count_next;

  // Response register
  logic              rsp_valid;
  status_t           rsp_status;
  status_t           status_next;
  logic [OCC_W-1:0]  rsp_occ;
  logic [KEY_W-1:0]  rsp_size;
  logic [ID_W-1:0]   rsp_id;
  slot_t             rd_slot;

  // Chain signals
  slot_t               slots [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] shift_vec;
  cell_op_t            op;

  logic exec;
  logic full;
  logic found;
  logic rank_ok;

  // Execute when a request waits and the response register is free
  assign exec      = rq_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !rq_valid || exec;

  assign full    = (held_count == CNT_W'(CAPACITY));
  assign found   = shift_vec[CAPACITY-1];
  assign rank_ok = (32'(rq_rank) < 32'(held_count));

  // Broadcast operation to the cells
  always_comb begin
    op.key   = rq_size;
    op.ident = rq_id;
    op.ins   = exec && (rq_type == REQ_INSERT) && !full;
    op.rem   = exec && (rq_type == REQ_REMOVE);
  end

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  left_lt;
    slot_t left_slot;
    slot_t right_slot;

    if (i == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_slot = '0;
    end else begin : g_mid
      assign left_lt   = lt_vec[i-1];
      assign left_slot = slots[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_slot = '0;
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end

    sofbt_cell u_cell (
      .clk        (clk),
      .op         (op),
      .here_valid (CNT_W'(i) < held_count),
      .left_lt    (left_lt),
      .shift      (shift_vec[i]),
      .left_slot  (left_slot),
      .right_slot (right_slot),
      .slot       (slots[i]),
      .lt         (lt_vec[i]),
      .match      (match_vec[i])
    );
  end

  // Mark every cell at or above the first match for a downward shift
  sofbt_prefix u_prefix (
    .flags  (match_vec),
    .prefix (shift_vec)
  );

  // Select the entry at the requested rank
  always_comb begin
    rd_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (32'(rq_rank) == 32'(i)) begin
        rd_slot = slots[i];
      end
    end
  end

  // Decode status and the new occupancy
  always_comb begin
    status_next     = ST_OK;
    held_count_next = held_count;
    case (rq_type)
      REQ_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          held_count_next = held_count + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          held_count_next = held_count - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      REQ_READ: begin
        if (!rank_ok) begin
          status_next = ST_BAD_RANK;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Hold control state: request stage, occupancy, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_valid   <= 1'b0;
      rsp_valid  <= 1'b0;
      held_count <= '0;
    end else begin
      if (req.ready) begin
        rq_valid <= req.valid;
      end
      if (exec) begin
        rsp_valid  <= 1'b1;
        held_count <= held_count_next;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture request and response payloads
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      rq_type <= req.req_type;
      rq_size <= req.block_size;
      rq_id   <= req.block_id;
      rq_rank <= req.rank;
    end
    if (exec) begin
      rsp_status <= status_next;
      rsp_occ    <= OCC_W'(held_count_next);
      if ((rq_type == REQ_READ) && rank_ok) begin
        rsp_size <= rd_slot.size;
        rsp_id   <= rd_slot.id;
      end else begin
        rsp_size <= '0;
        rsp_id   <= '0;
      end
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.occupancy  = rsp_occ;
  assign rsp.entry_size = rsp_size;
  assign rsp.entry_id   = rsp_id;

  // Occupancy never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  // A successful insert grows the table by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    op.ins |=> held_count == $past(held_count) + CNT_W'(1))
    else $error("insert did not grow the table");

  // A remove that finds its block shrinks the table by one
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (op.rem && found) |=> held_count == $past(held_count) - CNT_W'(1))
    else $error("remove did not shrink the table");

  // A waiting request is never lost
  a_req_kept: assert property (@(posedge clk) disable iff (rst)
    (rq_valid && !exec) |=> rq_valid)
    else $error("pending request dropped");

  // A failed read carries zero entry fields
  a_bad_rank_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == ST_BAD_RANK) |-> (rsp_size == '0 && rsp_id == '0))
    else $error("failed read returned entry data");

endmodule
